@@ rtl/core/rbsi_pkg.sv @@
// Shared types, constants and helpers for the ray versus box slab test.
// No dependencies; every other file of the block uses it.
package rbsi_pkg;

  // Quotient bits delivered by the slab divider, and the number of register stages in it.
  localparam int QW      = 32;
  localparam int DIV_LAT = QW + 3;

  localparam logic [1:0] AXIS_X    = 2'd0;
  localparam logic [1:0] AXIS_Y    = 2'd1;
  localparam logic [1:0] AXIS_Z    = 2'd2;
  localparam logic [1:0] AXIS_NONE = 2'd3;

  localparam logic [2:0] REG_ORIGIN_X = 3'd0;
  localparam logic [2:0] REG_ORIGIN_Y = 3'd1;
  localparam logic [2:0] REG_ORIGIN_Z = 3'd2;
  localparam logic [2:0] REG_DIR_X    = 3'd3;
  localparam logic [2:0] REG_DIR_Y    = 3'd4;
  localparam logic [2:0] REG_DIR_Z    = 3'd5;
  localparam logic [2:0] REG_MAX_DIST = 3'd6;

  // Running entry/exit interval while the axes are folded in.
  typedef struct packed {
    logic signed [32:0] near;
    logic signed [32:0] far;
    logic [1:0]         axis;
    logic               neg;
  } acc_t;

  // Folds one axis into the interval. A later axis wins the entry only
  // when strictly larger.
  function automatic acc_t fold_axis(acc_t acc, logic moving, logic signed [31:0] t_in,
                                     logic signed [31:0] t_out, logic [1:0] axis,
                                     logic dir_neg);
    acc_t r;
    logic signed [32:0] ti;
    logic signed [32:0] to;
    r  = acc;
    ti = {t_in[31], t_in};
    to = {t_out[31], t_out};
    if (moving && (ti > acc.near)) begin
      r.near = ti;
      r.axis = axis;
      r.neg  = ~dir_neg;
    end
    if (moving && (to < acc.far)) begin
      r.far = to;
    end
    return r;
  endfunction

endpackage

@@ rtl/core/rbsi_div.sv @@
// Pipelined signed divider for one slab distance: (diff << FRAC_BITS) / den,
// truncated toward zero and saturated to 32 bits. Uses rbsi_pkg.
module rbsi_div #(
  parameter int FRAC_BITS = 16
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic signed [32:0]       diff,
  input  logic signed [17:0]       den,
  output logic signed [rbsi_pkg::QW-1:0] q
);

  localparam int QW = rbsi_pkg::QW;
  localparam int NW = 33 + FRAC_BITS;
  localparam int HW = NW - QW;
  localparam int CW = (HW > 18) ? HW : 18;

  // Operand conditioning.
  logic [NW-1:0] mag_r;
  logic [17:0]   dmag_r;
  logic          neg0_r;
  logic [32:0]   dabs;

  assign dabs = diff[32] ? 33'(-diff) : 33'(diff);

  always_ff @(posedge clk) begin
    if (en) begin
      mag_r  <= {dabs, {FRAC_BITS{1'b0}}};
      dmag_r <= den[17] ? 18'(-den) : 18'(den);
      neg0_r <= diff[32] ^ den[17];
    end
  end

  // Overflow check: the high part of the dividend must stay below the
  // divisor, otherwise the quotient needs more than 32 bits.
  logic [17:0]   rem_r [0:QW];
  logic [QW-1:0] lo_r  [0:QW];
  logic [QW-1:0] quo_r [0:QW];
  logic          ovf_r [0:QW];
  logic          neg_r [0:QW];
  logic [CW-1:0] hi_ext;
  logic [CW-1:0] den_ext;

  assign hi_ext  = CW'(mag_r[NW-1:QW]);
  assign den_ext = CW'(dmag_r);

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= hi_ext[17:0];
      lo_r[0]  <= mag_r[QW-1:0];
      quo_r[0] <= '0;
      ovf_r[0] <= (hi_ext >= den_ext);
      neg_r[0] <= neg0_r;
    end
  end

  // One restoring quotient bit per stage.
  for (genvar k = 0; k < QW; k++) begin : g_step
    logic [18:0] trial;
    logic        take;
    assign trial = {rem_r[k], lo_r[k][QW-1]};
    assign take  = (trial >= {1'b0, dmag_r});
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k+1] <= take ? 18'(trial - {1'b0, dmag_r}) : trial[17:0];
        lo_r[k+1]  <= {lo_r[k][QW-2:0], 1'b0};
        quo_r[k+1] <= {quo_r[k][QW-2:0], take};
        ovf_r[k+1] <= ovf_r[k];
        neg_r[k+1] <= neg_r[k];
      end
    end
  end

  // Sign and saturation.
  logic [QW-1:0] qm;
  logic          big_pos;
  logic          big_neg;
  logic signed [QW-1:0] q_r;

  assign qm      = quo_r[QW];
  assign big_pos = ovf_r[QW] || qm[QW-1];
  assign big_neg = ovf_r[QW] || (qm > {1'b1, {(QW-1){1'b0}}});

  always_ff @(posedge clk) begin
    if (en) begin
      if (neg_r[QW]) begin
        q_r <= big_neg ? {1'b1, {(QW-1){1'b0}}} : QW'(-qm);
      end else begin
        q_r <= big_pos ? {1'b0, {(QW-1){1'b1}}} : qm;
      end
    end
  end

  assign q = q_r;

endmodule

@@ rtl/core/ray_box_slab_intersect.sv @@
// Ray versus axis-aligned box test; top level with configuration, pipeline
// control and the slab fold. Uses rbsi_pkg and rbsi_div.
//
// One box word is accepted every cycle that in_tready is high and one result
// word leaves for each, in order. Each passes stage A, the six bit-per-stage
// slab dividers (one quotient bit per stage), stages C and D, and the output
// register of stage E. While a result word waits with out_tready low the
// whole pipeline holds and in_tready is low; otherwise in_tready is high.
// Configuration writes are always accepted and must only be issued while
// no box is in flight. A write to an index past max_distance is ignored.
module ray_box_slab_intersect #(
  parameter int FRAC_BITS = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  // box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z, box_tag
  input  logic [207:0]  in_tdata,
  output logic          out_tvalid,
  input  logic          out_tready,
  // hit, hit_distance, normal_axis, normal_negative, result_tag, zero fill
  output logic [55:0]   out_tdata,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [2:0]    cfg_index,
  input  logic [31:0]   cfg_data
);

  localparam int DIV_LAT = rbsi_pkg::DIV_LAT;
  localparam longint DIR_EPS = (64'd1 << FRAC_BITS) / 64'd1000000;

  // Configuration registers.
  logic signed [31:0] origin_r [0:2];
  logic signed [17:0] dir_r    [0:2];
  logic [30:0]        maxd_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        origin_r[i] <= '0;
        dir_r[i]    <= '0;
      end
      maxd_r <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        rbsi_pkg::REG_ORIGIN_X: origin_r[0] <= cfg_data;
        rbsi_pkg::REG_ORIGIN_Y: origin_r[1] <= cfg_data;
        rbsi_pkg::REG_ORIGIN_Z: origin_r[2] <= cfg_data;
        rbsi_pkg::REG_DIR_X:    dir_r[0]    <= cfg_data[17:0];
        rbsi_pkg::REG_DIR_Y:    dir_r[1]    <= cfg_data[17:0];
        rbsi_pkg::REG_DIR_Z:    dir_r[2]    <= cfg_data[17:0];
        rbsi_pkg::REG_MAX_DIST: maxd_r      <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  // An axis whose direction is within epsilon of zero is parallel.
  logic [2:0] moving;
  for (genvar a = 0; a < 3; a++) begin : g_mv
    logic [17:0] dmag;
    assign dmag      = dir_r[a][17] ? 18'(-dir_r[a]) : 18'(dir_r[a]);
    assign moving[a] = (64'(dmag) > 64'(DIR_EPS));
  end

  logic en;
  logic out_tvalid_r;
  assign en        = !out_tvalid_r || out_tready;
  assign in_tready = en;

  // Stage A: slab offsets and the parallel-axis containment test.
  logic signed [32:0] diff_r [0:5];
  logic               a_vld_r;
  logic [15:0]        a_tag_r;
  logic               a_pfail_r;
  logic [2:0]         pfail;

  for (genvar a = 0; a < 3; a++) begin : g_sa
    logic signed [31:0] bmin;
    logic signed [31:0] bmax;
    assign bmin     = in_tdata[32*a +: 32];
    assign bmax     = in_tdata[96 + 32*a +: 32];
    assign pfail[a] = !moving[a] && ((origin_r[a] < bmin) || (origin_r[a] > bmax));
    always_ff @(posedge clk) begin
      if (en) begin
        diff_r[2*a]   <= {bmin[31], bmin} - {origin_r[a][31], origin_r[a]};
        diff_r[2*a+1] <= {bmax[31], bmax} - {origin_r[a][31], origin_r[a]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else if (en) begin
      a_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_tag_r   <= in_tdata[207:192];
      a_pfail_r <= |pfail;
    end
  end

  // Slab dividers, even index the minimum bound and odd the maximum.
  logic signed [31:0] t_q [0:5];
  for (genvar i = 0; i < 6; i++) begin : g_div
    rbsi_div #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clk  (clk),
      .en   (en),
      .diff (diff_r[i]),
      .den  (dir_r[i/2]),
      .q    (t_q[i])
    );
  end

  // Valid, tag and parallel-miss flag ride alongside the dividers.
  logic        dv_r [0:DIV_LAT-1];
  logic [15:0] dt_r [0:DIV_LAT-1];
  logic        df_r [0:DIV_LAT-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < DIV_LAT; k++) dv_r[k] <= 1'b0;
    end else if (en) begin
      dv_r[0] <= a_vld_r;
      for (int k = 1; k < DIV_LAT; k++) dv_r[k] <= dv_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dt_r[0] <= a_tag_r;
      df_r[0] <= a_pfail_r;
      for (int k = 1; k < DIV_LAT; k++) begin
        dt_r[k] <= dt_r[k-1];
        df_r[k] <= df_r[k-1];
      end
    end
  end

  // Stage C: order entry and exit per axis.
  logic signed [31:0] tin_r  [0:2];
  logic signed [31:0] tout_r [0:2];
  logic               c_vld_r;
  logic [15:0]        c_tag_r;
  logic               c_pfail_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int a = 0; a < 3; a++) begin
        if (t_q[2*a] > t_q[2*a+1]) begin
          tin_r[a]  <= t_q[2*a+1];
          tout_r[a] <= t_q[2*a];
        end else begin
          tin_r[a]  <= t_q[2*a];
          tout_r[a] <= t_q[2*a+1];
        end
      end
      c_tag_r   <= dt_r[DIV_LAT-1];
      c_pfail_r <= df_r[DIV_LAT-1];
    end
  end

  // Stage D: fold the x and y slabs.
  rbsi_pkg::acc_t acc_init;
  rbsi_pkg::acc_t acc_d_nxt;
  rbsi_pkg::acc_t acc_d_r;
  logic signed [31:0] d_tin_r;
  logic signed [31:0] d_tout_r;
  logic               d_vld_r;
  logic [15:0]        d_tag_r;
  logic               d_pfail_r;

  always_comb begin
    acc_init.near = '0;
    acc_init.far  = {2'b00, maxd_r};
    acc_init.axis = rbsi_pkg::AXIS_NONE;
    acc_init.neg  = 1'b0;
    acc_d_nxt = rbsi_pkg::fold_axis(acc_init, moving[0], tin_r[0], tout_r[0],
                                    rbsi_pkg::AXIS_X, dir_r[0][17]);
    acc_d_nxt = rbsi_pkg::fold_axis(acc_d_nxt, moving[1], tin_r[1], tout_r[1],
                                    rbsi_pkg::AXIS_Y, dir_r[1][17]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      acc_d_r   <= acc_d_nxt;
      d_tin_r   <= tin_r[2];
      d_tout_r  <= tout_r[2];
      d_tag_r   <= c_tag_r;
      d_pfail_r <= c_pfail_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_vld_r      <= 1'b0;
      d_vld_r      <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else if (en) begin
      c_vld_r      <= dv_r[DIV_LAT-1];
      d_vld_r      <= c_vld_r;
      out_tvalid_r <= d_vld_r;
    end
  end

  // Stage E: z slab, hit decision and the output register.
  rbsi_pkg::acc_t acc_e;
  logic           hit;
  logic [55:0]    out_tdata_r;

  always_comb begin
    acc_e = rbsi_pkg::fold_axis(acc_d_r, moving[2], d_tin_r, d_tout_r,
                                rbsi_pkg::AXIS_Z, dir_r[2][17]);
    hit = !d_pfail_r && (acc_e.near <= acc_e.far) && !acc_e.near[32]
          && (acc_e.near <= $signed({2'b00, maxd_r}));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_tdata_r[55:51] <= '0;
      out_tdata_r[50:35] <= d_tag_r;
      if (hit) begin
        out_tdata_r[0]     <= 1'b1;
        out_tdata_r[31:1]  <= acc_e.near[30:0];
        out_tdata_r[33:32] <= acc_e.axis;
        out_tdata_r[34]    <= (acc_e.axis == rbsi_pkg::AXIS_NONE) ? 1'b0 : acc_e.neg;
      end else begin
        out_tdata_r[0]     <= 1'b0;
        out_tdata_r[31:1]  <= '0;
        out_tdata_r[33:32] <= rbsi_pkg::AXIS_NONE;
        out_tdata_r[34]    <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule

@@ rtl/core/rbsi_check.sv @@
// Port-level checks for ray_box_slab_intersect, attached with a bind.
// Uses rbsi_pkg for the axis codes.
module rbsi_check (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [55:0] out_tdata
);

  // A waiting result word must not change.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("result word changed while stalled");

  // A miss carries zero distance and no face.
  a_miss: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[0] |-> out_tdata[31:1] == 31'd0
      && out_tdata[33:32] == rbsi_pkg::AXIS_NONE && !out_tdata[34])
    else $error("miss word has nonzero fields");

  // Without a face there is no normal sign.
  a_noface: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[33:32] == rbsi_pkg::AXIS_NONE |-> !out_tdata[34])
    else $error("normal sign set without a face");

  // The pipeline stalls input only when a result word waits.
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && !out_tready)
    else $error("input stalled without a waiting result");

endmodule

bind ray_box_slab_intersect rbsi_check u_rbsi_check (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
